// File: rtl/nos_pkg.sv
// ----------------------------------------------------------------------------
// nos_pkg
// Shared types and constants of the note-off scheduler: transaction payloads,
// the slot memory entry, command codes and the controller state encoding.
// ----------------------------------------------------------------------------
package nos_pkg;

    localparam logic       CMD_ADD         = 1'b0;
    localparam logic       CMD_TICK        = 1'b1;
    localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;

    typedef struct packed {
        logic       cmd;
        logic [1:0] out_port;
        logic [3:0] midi_channel;
        logic [6:0] note_number;
        logic [7:0] note_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0] dest_port;
        logic [7:0] status_byte;
        logic [6:0] off_note;
        logic       velocity_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] count;
        logic [6:0] note;
        logic [3:0] channel;
        logic [1:0] port;
    } slot_entry_t;

    typedef struct packed {
        logic push;
        logic flush;
    } oq_ctrl_t;

    typedef struct packed {
        logic push_ok;
        logic pend_valid;
    } oq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_FLUSH
    } nos_state_t;

endpackage

// File: rtl/nos_slot_mem.sv
// ----------------------------------------------------------------------------
// nos_slot_mem
// Single-port-write, single-port-read slot memory holding the pulse count,
// note, channel and port of every slot. Read data is registered.
// ----------------------------------------------------------------------------
module nos_slot_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  nos_pkg::slot_entry_t wdata,
    input  logic                re,
    input  logic [IDX_W-1:0]    raddr,
    output nos_pkg::slot_entry_t rdata
);
    import nos_pkg::*;

    slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds when no read is issued, so a stalled consumer keeps it.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/nos_out_queue.sv
// ----------------------------------------------------------------------------
// nos_out_queue
// One pending note-off plus the output register. A note-off waits in the
// pending stage until the next one arrives (last clear) or the scan ends
// (last set).
// ----------------------------------------------------------------------------
module nos_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nos_pkg::oq_ctrl_t    ctrl,
    input  nos_pkg::out_item_t   push_data,
    output nos_pkg::oq_status_t  status,
    output logic                 result_valid,
    input  logic                 result_ready,
    output nos_pkg::out_item_t   result
);
    import nos_pkg::*;

    out_item_t pend_reg;
    logic      pend_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      load_out;
    out_item_t out_item_next;

    assign out_free = !out_valid_reg || result_ready;
    assign load_out = pend_valid_reg && (ctrl.push || (ctrl.flush && out_free));

    always_comb
    begin
        out_item_next      = pend_reg;
        out_item_next.last = ctrl.flush;
    end

    assign status.push_ok    = !pend_valid_reg || out_free;
    assign status.pend_valid = pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (ctrl.flush && out_free)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            pend_reg <= push_data;
        end
        if (load_out)
        begin
            out_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: rtl/note_off_scheduler.sv
// ----------------------------------------------------------------------------
// note_off_scheduler
// Table of note slots that schedules MIDI note-off messages on clock pulses.
// ----------------------------------------------------------------------------
// An add transaction (cmd 0) walks the slots from slot 0, one slot per cycle,
// and stores the note in the first free one; when every slot is busy it is
// dropped without any result. A tick transaction (cmd 1) sweeps the slot
// memory once, reading one slot per cycle through its single read port while
// the sweep is not stalled, and writes the decremented count back from the
// registered read data. The sweep stalls when the result side holds off a
// note-off, and the next transaction is accepted only once the tick is done.
// Every slot whose count reaches zero is freed and yields one note-off
// transaction in slot order; the final one of a tick carries last.
// A tick in which nothing expires yields no transaction at all. The active
// flags live in flip-flops and are cleared by reset; the slot data needs no
// initialisation, so the block is ready straight after reset.
// ----------------------------------------------------------------------------
module note_off_scheduler #(
    parameter int NUM_SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  nos_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output nos_pkg::out_item_t result
);
    import nos_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    nos_state_t            state_reg, state_next;
    in_item_t              item_reg, item_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  p_valid_reg, p_valid_next;
    logic [IDX_W-1:0]      p_idx_reg, p_idx_next;
    logic [NUM_SLOTS-1:0]  active_reg, active_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    slot_entry_t           mem_wdata;
    logic                  mem_re;
    slot_entry_t           mem_rdata;

    oq_ctrl_t              oq_ctrl;
    oq_status_t            oq_status;
    out_item_t             push_data;

    slot_entry_t           add_entry;
    slot_entry_t           dec_entry;
    logic                  scan_last;
    logic                  scan_free;
    logic                  p_active;
    logic                  p_zero;
    logic                  advance;

    nos_slot_mem #(
        .DEPTH (NUM_SLOTS),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (scan_idx_reg),
        .rdata (mem_rdata)
    );

    nos_out_queue u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (oq_ctrl),
        .push_data    (push_data),
        .status       (oq_status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The entry an add writes: a length of zero is kept as one pulse.
    always_comb
    begin
        add_entry.count   = (item_reg.note_length == 8'd0) ? 8'd1 : item_reg.note_length;
        add_entry.note    = item_reg.note_number;
        add_entry.channel = item_reg.midi_channel;
        add_entry.port    = item_reg.out_port;
    end

    // The registered read data of the slot read last is processed now: decrement
    // and either write the new count back or free the slot and emit a note-off.
    always_comb
    begin
        dec_entry       = mem_rdata;
        dec_entry.count = mem_rdata.count - 8'd1;
    end

    assign p_active  = active_reg[p_idx_reg];
    assign p_zero    = (dec_entry.count == 8'd0);
    assign scan_last = (scan_idx_reg == LAST_IDX);
    assign scan_free = !active_reg[scan_idx_reg];

    // The sweep stalls only when a note-off is due and the pending stage
    // cannot hand its previous note-off to the output register.
    assign advance = !(p_valid_reg && p_active && p_zero && !oq_status.push_ok);

    always_comb
    begin
        push_data.dest_port     = mem_rdata.port;
        push_data.status_byte   = NOTE_OFF_STATUS | {4'b0000, mem_rdata.channel};
        push_data.off_note      = mem_rdata.note;
        push_data.velocity_byte = 1'b0;
        push_data.last          = 1'b0;
    end

    assign item_ready = (state_reg == ST_IDLE);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (item.cmd == CMD_ADD) ? ST_ADD : ST_TICK;
                end
            end
            ST_ADD:
            begin
                if (scan_free || scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (advance && issue_done_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!oq_status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        item_next       = item_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        p_valid_next    = p_valid_reg;
        p_idx_next      = p_idx_reg;
        active_next     = active_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_idx_reg;
        mem_wdata       = add_entry;
        mem_re          = 1'b0;
        oq_ctrl         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next       = item;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    p_valid_next    = 1'b0;
                end
            end
            ST_ADD:
            begin
                if (scan_free)
                begin
                    mem_we                    = 1'b1;
                    active_next[scan_idx_reg] = 1'b1;
                end
                else if (!scan_last)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_TICK:
            begin
                if (advance)
                begin
                    if (p_valid_reg && p_active)
                    begin
                        if (p_zero)
                        begin
                            active_next[p_idx_reg] = 1'b0;
                            oq_ctrl.push           = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = p_idx_reg;
                            mem_wdata = dec_entry;
                        end
                    end
                    if (!issue_done_reg)
                    begin
                        mem_re       = 1'b1;
                        p_valid_next = 1'b1;
                        p_idx_next   = scan_idx_reg;
                        if (scan_last)
                        begin
                            issue_done_next = 1'b1;
                        end
                        else
                        begin
                            scan_idx_next = scan_idx_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        p_valid_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                oq_ctrl.flush = 1'b1;
            end
            default:
            begin
                oq_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            active_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            p_valid_reg    <= p_valid_next;
            active_reg     <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        p_idx_reg <= p_idx_next;
    end

endmodule
